// ===== rtl/cbbs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the cartridge bus byte sequencer.
// Used by cbbs_step and the top level; depends on nothing.
package cbbs_pkg;

   localparam int ADDR_BITS   = 24;
   localparam int COUNT_BITS  = 25;
   localparam int CSR_BITS    = 25;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [ADDR_BITS-1:0] ROM_MASK   = 24'h800000;
   localparam logic [ADDR_BITS-1:0] CE_MASK    = 24'hC00000;
   localparam logic [ADDR_BITS-1:0] PAGE_MASK  = 24'hFFFF00;
   localparam logic [ADDR_BITS-1:0] TIME_PAGE  = 24'hA13000;

   localparam logic [CSR_IDX_BITS-1:0] CSR_DIRECTION     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LANE_MODE     = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_ADDRESS = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TRANSFER_SIZE = 2'd3;

   typedef enum logic [1:0] {
      LANE_NONE = 2'd0,
      LANE_LOW  = 2'd1,
      LANE_HIGH = 2'd2,
      LANE_BOTH = 2'd3
   } lane_mode_type;

   typedef struct packed {
      logic                  direction;      // 1 for write transfers
      lane_mode_type         lane_mode;
      logic [ADDR_BITS-1:0]  start_address;
      logic [COUNT_BITS-1:0] transfer_size;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]  current_address;
      logic [COUNT_BITS-1:0] remaining_bytes;
      logic [7:0]            held_high_byte;
      logic                  high_byte_held;
      logic                  address_pending;
      logic [15:0]           driven_lanes;
   } seq_state_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] bus_address;
      logic                 new_address_phase;
      logic                 rom_select;
      logic                 chip_enable;
      logic                 time_select;
      logic                 read_strobe;
      logic                 lower_write_strobe;
      logic                 upper_write_strobe;
      logic [15:0]          bus_data_out;
      logic [7:0]           read_byte;
      logic                 last_byte;
   } result_type;

   // Start address as the lane mode forces its low bit.
   function automatic logic [ADDR_BITS-1:0] adjusted_start(
      input logic [ADDR_BITS-1:0] start,
      input lane_mode_type        mode
   );
      logic [ADDR_BITS-1:0] a;
      a = start;
      if (mode == LANE_HIGH) begin
         a[0] = 1'b0;
      end else if (mode == LANE_LOW) begin
         a[0] = 1'b1;
      end
      return a;
   endfunction

endpackage

// ===== rtl/cbbs_in_reg.sv =====
`timescale 1ns / 1ps
// Input register for the request channel of the byte sequencer.
// Does not depend on cbbs_pkg.
module cbbs_in_reg (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [7:0]  req_write_byte,
   input  logic [15:0] req_bus_word,
   input  logic        advance,
   output logic        req_stall,
   output logic        held_valid,
   output logic [7:0]  held_write_byte,
   output logic [15:0] held_bus_word
);

   logic        valid_ff;
   logic [7:0]  write_byte_ff;
   logic [15:0] bus_word_ff;
   logic        slot_free;

   // The slot opens when empty or when its item moves on this cycle.
   assign slot_free = !valid_ff || advance;
   assign req_stall = !slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (slot_free) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free && req_valid) begin
         write_byte_ff <= req_write_byte;
         bus_word_ff   <= req_bus_word;
      end
   end

   assign held_valid      = valid_ff;
   assign held_write_byte = write_byte_ff;
   assign held_bus_word   = bus_word_ff;

endmodule

// ===== rtl/cbbs_step.sv =====
`timescale 1ns / 1ps
// Per-item step logic: next sequencer state and the bus cycle for one byte.
// Depends on cbbs_pkg.
module cbbs_step (
   input  cbbs_pkg::seq_state_type state_cur,
   input  cbbs_pkg::cfg_type       cfg,
   input  logic [7:0]              write_byte,
   input  logic [15:0]             bus_word,
   output cbbs_pkg::seq_state_type state_next,
   output logic                    emit,
   output cbbs_pkg::result_type    result
);

   logic [cbbs_pkg::ADDR_BITS-1:0]  a;
   logic [cbbs_pkg::ADDR_BITS-1:0]  shown;
   logic [cbbs_pkg::COUNT_BITS-1:0] rem_dec;
   logic [cbbs_pkg::COUNT_BITS-1:0] rem_dec2;

   assign a        = state_cur.current_address;
   assign rem_dec  = state_cur.remaining_bytes - cbbs_pkg::COUNT_BITS'(1);
   assign rem_dec2 = (state_cur.remaining_bytes >= cbbs_pkg::COUNT_BITS'(2)) ?
                     state_cur.remaining_bytes - cbbs_pkg::COUNT_BITS'(2) :
                     '0;

   always_comb begin
      state_next = state_cur;
      emit       = 1'b0;
      result     = '0;
      shown      = a;

      if (state_cur.remaining_bytes == '0) begin
         emit = 1'b0;
      end else if (!cfg.direction) begin
         // read cycle; the odd half of a word shares the even address phase
         emit   = 1'b1;
         shown  = state_cur.address_pending ? a : {a[cbbs_pkg::ADDR_BITS-1:1], 1'b0};
         result.new_address_phase = state_cur.address_pending;
         result.read_strobe       = 1'b1;
         state_next.address_pending = 1'b1;
         case (cfg.lane_mode)
            cbbs_pkg::LANE_LOW: begin
               result.read_byte = bus_word[7:0];
               state_next.current_address = a + cbbs_pkg::ADDR_BITS'(2);
            end
            cbbs_pkg::LANE_HIGH: begin
               result.read_byte = bus_word[15:8];
               state_next.current_address = a + cbbs_pkg::ADDR_BITS'(2);
            end
            cbbs_pkg::LANE_BOTH: begin
               if (a[0]) begin
                  result.read_byte = bus_word[7:0];
               end else begin
                  result.read_byte = bus_word[15:8];
                  state_next.address_pending = 1'b0;
               end
               state_next.current_address = a + cbbs_pkg::ADDR_BITS'(1);
            end
            default: begin
               result.read_byte = 8'h00;
            end
         endcase
         state_next.remaining_bytes = rem_dec;
         if (rem_dec == '0) begin
            state_next.address_pending = 1'b1;
         end
         result.last_byte = (rem_dec == '0);
      end else if (state_cur.high_byte_held) begin
         // second half of a merged word write
         emit = 1'b1;
         result.new_address_phase   = 1'b1;
         result.lower_write_strobe  = 1'b1;
         result.upper_write_strobe  = 1'b1;
         state_next.driven_lanes    = {state_cur.held_high_byte, write_byte};
         state_next.current_address = a + cbbs_pkg::ADDR_BITS'(2);
         state_next.remaining_bytes = rem_dec2;
         state_next.high_byte_held  = 1'b0;
         state_next.held_high_byte  = 8'h00;
         result.bus_data_out        = {state_cur.held_high_byte, write_byte};
         result.last_byte           = (rem_dec2 == '0);
      end else if (cfg.lane_mode == cbbs_pkg::LANE_BOTH && !a[0] &&
                   state_cur.remaining_bytes > cbbs_pkg::COUNT_BITS'(1)) begin
         // hold the even byte until its partner arrives
         emit = 1'b0;
         state_next.held_high_byte = write_byte;
         state_next.high_byte_held = 1'b1;
      end else begin
         emit = 1'b1;
         result.new_address_phase = 1'b1;
         case (cfg.lane_mode)
            cbbs_pkg::LANE_LOW: begin
               state_next.driven_lanes[7:0] = write_byte;
               result.lower_write_strobe    = 1'b1;
               state_next.current_address   = a + cbbs_pkg::ADDR_BITS'(2);
            end
            cbbs_pkg::LANE_HIGH: begin
               state_next.driven_lanes[15:8] = write_byte;
               result.upper_write_strobe     = 1'b1;
               state_next.current_address    = a + cbbs_pkg::ADDR_BITS'(2);
            end
            cbbs_pkg::LANE_BOTH: begin
               if (a[0]) begin
                  state_next.driven_lanes[7:0] = write_byte;
                  result.lower_write_strobe    = 1'b1;
               end else begin
                  state_next.driven_lanes[15:8] = write_byte;
                  result.upper_write_strobe     = 1'b1;
               end
               state_next.current_address = a + cbbs_pkg::ADDR_BITS'(1);
            end
            default: begin
               // consume the byte, drive nothing new
               state_next.driven_lanes = state_cur.driven_lanes;
            end
         endcase
         state_next.remaining_bytes = rem_dec;
         result.bus_data_out        = state_next.driven_lanes;
         result.last_byte           = (rem_dec == '0);
      end

      result.bus_address = shown;
      result.rom_select  = ((shown & cbbs_pkg::ROM_MASK) == '0);
      result.chip_enable = ((shown & cbbs_pkg::CE_MASK) == '0);
      result.time_select = ((shown & cbbs_pkg::PAGE_MASK) == cbbs_pkg::TIME_PAGE);
      if (!emit) begin
         result = '0;
      end
   end

endmodule

// ===== rtl/cartridge_bus_byte_sequencer.sv =====
`timescale 1ns / 1ps
// Top level of the cartridge bus byte sequencer: configuration registers,
// sequencer state, output register. Uses cbbs_pkg, cbbs_in_reg, cbbs_step.
//
// One host byte enters per cycle on req_* while req_stall is low; each byte passes
// an input register and then the step logic, and any bus cycle it gives goes into
// the output register before it appears on rsp_*; a new byte is taken every cycle
// while rsp_stall is low; the state of address, byte count and held byte is
// updated for each byte taken. A byte gives no item when the transfer is
// idle (count zero) or when it is the even half of a merged two-lane write;
// the merged word follows with the next byte. Any csr write re-arms the
// transfer from start_address and transfer_size; write only while idle.
module cartridge_bus_byte_sequencer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [cbbs_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [cbbs_pkg::CSR_BITS-1:0]        csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_write_byte,
   input  logic [15:0]                          req_bus_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [cbbs_pkg::ADDR_BITS-1:0]       rsp_bus_address,
   output logic                                 rsp_new_address_phase,
   output logic                                 rsp_rom_select,
   output logic                                 rsp_chip_enable,
   output logic                                 rsp_time_select,
   output logic                                 rsp_read_strobe,
   output logic                                 rsp_lower_write_strobe,
   output logic                                 rsp_upper_write_strobe,
   output logic [15:0]                          rsp_bus_data_out,
   output logic [7:0]                           rsp_read_byte,
   output logic                                 rsp_last_byte
);

   cbbs_pkg::cfg_type       cfg_ff;
   cbbs_pkg::cfg_type       cfg_in;
   cbbs_pkg::seq_state_type state_ff;
   cbbs_pkg::seq_state_type state_in;
   cbbs_pkg::seq_state_type step_state;
   cbbs_pkg::result_type    step_result;
   cbbs_pkg::result_type    result_ff;
   logic                    rsp_valid_ff;
   logic                    step_emit;
   logic                    held_valid;
   logic [7:0]              held_write_byte;
   logic [15:0]             held_bus_word;
   logic                    out_free;
   logic                    fire;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire     = held_valid && out_free;

   cbbs_in_reg u_in_reg (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_write_byte  (req_write_byte),
      .req_bus_word    (req_bus_word),
      .advance         (fire),
      .req_stall       (req_stall),
      .held_valid      (held_valid),
      .held_write_byte (held_write_byte),
      .held_bus_word   (held_bus_word)
   );

   cbbs_step u_step (
      .state_cur  (state_ff),
      .cfg        (cfg_ff),
      .write_byte (held_write_byte),
      .bus_word   (held_bus_word),
      .state_next (step_state),
      .emit       (step_emit),
      .result     (step_result)
   );

   // Register writes and the re-arm that follows them.
   always_comb begin
      cfg_in   = cfg_ff;
      state_in = state_ff;
      if (csr_write_enable) begin
         case (csr_index)
            cbbs_pkg::CSR_DIRECTION:     cfg_in.direction = csr_write_data[0];
            cbbs_pkg::CSR_LANE_MODE:
               cfg_in.lane_mode = cbbs_pkg::lane_mode_type'(csr_write_data[1:0]);
            cbbs_pkg::CSR_START_ADDRESS:
               cfg_in.start_address = csr_write_data[cbbs_pkg::ADDR_BITS-1:0];
            cbbs_pkg::CSR_TRANSFER_SIZE:
               cfg_in.transfer_size = csr_write_data[cbbs_pkg::COUNT_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
         state_in.current_address =
            cbbs_pkg::adjusted_start(cfg_in.start_address, cfg_in.lane_mode);
         state_in.remaining_bytes = cfg_in.transfer_size;
         state_in.held_high_byte  = 8'h00;
         state_in.high_byte_held  = 1'b0;
         state_in.address_pending = 1'b1;
      end else if (fire) begin
         state_in = step_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.direction     <= 1'b0;
         cfg_ff.lane_mode     <= cbbs_pkg::LANE_BOTH;
         cfg_ff.start_address <= '0;
         cfg_ff.transfer_size <= '0;
         state_ff.current_address <= '0;
         state_ff.remaining_bytes <= '0;
         state_ff.held_high_byte  <= 8'h00;
         state_ff.high_byte_held  <= 1'b0;
         state_ff.address_pending <= 1'b1;
         state_ff.driven_lanes    <= 16'h0000;
      end else begin
         cfg_ff   <= cfg_in;
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= fire && step_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && fire && step_emit) begin
         result_ff <= step_result;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_bus_address        = result_ff.bus_address;
   assign rsp_new_address_phase  = result_ff.new_address_phase;
   assign rsp_rom_select         = result_ff.rom_select;
   assign rsp_chip_enable        = result_ff.chip_enable;
   assign rsp_time_select        = result_ff.time_select;
   assign rsp_read_strobe        = result_ff.read_strobe;
   assign rsp_lower_write_strobe = result_ff.lower_write_strobe;
   assign rsp_upper_write_strobe = result_ff.upper_write_strobe;
   assign rsp_bus_data_out       = result_ff.bus_data_out;
   assign rsp_read_byte          = result_ff.read_byte;
   assign rsp_last_byte          = result_ff.last_byte;

endmodule
